>>> design/assert_macros.svh
// Assertion macros used by the encoder design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/b4k_pkg.sv
// Types and constants of the base-4096 encoder.
package b4k_pkg;

    localparam logic [15:0] PAD_SYMBOL   = 16'hF001;
    localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;
    localparam int          QUEUE_DEPTH  = 4;
    localparam int          MAX_PER_BYTE = 3;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

endpackage

>>> design/base4096_encoder.sv
// Base-4096 encoder: bytes in, 12-bit symbols out, per-message symbol limit.
//
//  channel    | direction | tdata / data                | tlast / flag
//  -----------+-----------+-----------------------------+-------------------
//  s (bytes)  | in        | [7:0] data_byte             | end_of_message
//  m (symbols)| out       | [15:0] symbol               | last_symbol
//  cfg        | in        | [15:0] symbol_limit         | -
//
// One byte is taken per cycle; its symbols land in a four-entry result queue
// in the cycle after and leave one per cycle. A final byte after one held byte
// yields three symbols, so the queue sets the rate: bytes are taken while at
// most one symbol waits. Reset is synchronous, active low, and clears the
// message state, the queue and sets symbol_limit to 65535. The cfg channel is
// always ready; a stall on the symbol side backs up into the byte side.
`include "assert_macros.svh"

module base4096_encoder #(
    parameter int QDEPTH = b4k_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_message
    // symbol output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] symbol
    output logic        o_m_tlast,   // last_symbol
    // limit register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // [15:0] symbol_limit
);

    localparam int CW = $clog2(QDEPTH + 1);
    localparam int NPB = b4k_pkg::MAX_PER_BYTE;

    // message state
    b4k_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic [15:0]     r_count, n_count;
    logic [15:0]     r_limit;

    // result queue, entry 0 is the head
    logic [15:0]     r_sym  [QDEPTH];
    logic [QDEPTH-1:0] r_last;
    logic [CW-1:0]   r_cnt;
    logic [15:0]     n_sym  [QDEPTH];
    logic [QDEPTH-1:0] n_last;
    logic [CW-1:0]   n_cnt;

    // candidate symbols of the current byte
    logic [15:0]     c_sym  [NPB];
    logic [NPB-1:0]  c_fin;
    logic [1:0]      c_num;
    logic [16:0]     rem;
    logic [1:0]      keep_num;
    logic [NPB-1:0]  c_lastflag;

    logic            acc;
    logic            pop;
    logic            eom_acc;
    logic [CW-1:0]   base;
    logic [15:0]     sh_sym [QDEPTH];
    logic [QDEPTH-1:0] sh_last;

    assign acc         = i_s_tvalid && o_s_tready;
    assign pop         = o_m_tvalid && i_m_tready;
    assign eom_acc     = acc && i_s_tlast;
    assign o_s_tready  = (r_cnt <= CW'(QDEPTH - NPB));
    assign o_m_tvalid  = (r_cnt != '0);
    assign o_m_tdata   = r_sym[0];
    assign o_m_tlast   = r_last[0];
    assign o_cfg_ready = 1'b1;

    // candidates for this byte, by phase
    always_comb begin
        c_sym[0] = '0;
        c_sym[1] = {4'h0, i_s_tdata[3:0], 8'h00};
        c_sym[2] = b4k_pkg::PAD_SYMBOL;
        c_fin    = '0;
        c_num    = 2'd0;
        unique case (r_phase)
            b4k_pkg::PH_1: begin
                c_sym[0] = {4'h0, r_held, i_s_tdata[7:4]};
                if (i_s_tlast) begin
                    c_num = 2'd3;
                    c_fin = 3'b100;
                end else begin
                    c_num = 2'd1;
                end
            end
            b4k_pkg::PH_2: begin
                c_sym[0] = {4'h0, r_held[3:0], i_s_tdata};
                c_num    = 2'd1;
                c_fin[0] = i_s_tlast;
            end
            default: begin
                // phase 0, and the unused code acts the same
                c_sym[0] = {4'h0, i_s_tdata, 4'h0};
                c_num    = i_s_tlast ? 2'd1 : 2'd0;
                c_fin[0] = i_s_tlast;
            end
        endcase
    end

    // limit check: symbols left before the limit, as a signed 17-bit value
    always_comb begin
        rem      = {1'b0, r_limit} - {1'b0, r_count};
        keep_num = 2'd0;
        for (int j = 0; j < NPB; j++) begin
            if (!rem[16] && rem > 17'(j) && 2'(j) < c_num) begin
                keep_num = 2'(j + 1);
            end
            c_lastflag[j] = c_fin[j] || (rem == 17'(j + 1));
        end
    end

    // next message state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_count = r_count;
        if (acc) begin
            n_count = r_count + 16'(keep_num);
            unique case (r_phase)
                b4k_pkg::PH_1: begin
                    n_phase = b4k_pkg::PH_2;
                    n_held  = i_s_tdata;
                end
                b4k_pkg::PH_2: begin
                    n_phase = b4k_pkg::PH_0;
                    n_held  = '0;
                end
                default: begin
                    n_phase = b4k_pkg::PH_1;
                    n_held  = i_s_tdata;
                end
            endcase
            if (i_s_tlast) begin
                n_phase = b4k_pkg::PH_0;
                n_held  = '0;
                n_count = '0;
            end
        end
    end

    // queue: drop the head on a transfer, append the kept symbols behind
    always_comb begin
        logic [CW-1:0] off;
        logic [1:0]    add;
        add = acc ? keep_num : 2'd0;
        for (int i = 0; i < QDEPTH - 1; i++) begin
            sh_sym[i]  = pop ? r_sym[i+1] : r_sym[i];
            sh_last[i] = pop ? r_last[i+1] : r_last[i];
        end
        sh_sym[QDEPTH-1]  = r_sym[QDEPTH-1];
        sh_last[QDEPTH-1] = r_last[QDEPTH-1];
        base  = r_cnt - CW'(pop);
        n_cnt = base + CW'(add);
        for (int i = 0; i < QDEPTH; i++) begin
            off       = CW'(i) - base;
            n_sym[i]  = sh_sym[i];
            n_last[i] = sh_last[i];
            if (CW'(i) >= base && off < CW'(add)) begin
                n_sym[i]  = c_sym[off[1:0]];
                n_last[i] = c_lastflag[off[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b4k_pkg::PH_0;
            r_held  <= '0;
            r_count <= '0;
            r_limit <= b4k_pkg::LIMIT_RESET;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_sym[i] <= n_sym[i];
        end
        r_last <= n_last;
    end

    property p_eom_clears;
        eom_acc |=> (r_count == '0 && r_phase == b4k_pkg::PH_0);
    endproperty

    property p_count_grows;
        ($past(i_rst_n) && !$past(eom_acc)) |-> (r_count >= $past(r_count));
    endproperty

    `ASSERT_CLK(a_queue_bound, r_cnt <= CW'(QDEPTH), "result queue over capacity")
    `ASSERT_CLK(a_eom_clears, p_eom_clears, "message state not cleared after final byte")
    `ASSERT_CLK(a_count_grows, p_count_grows, "symbol count fell within a message")
    `ASSERT_ALWAYS(a_cfg_ready, o_cfg_ready, "limit write channel not ready")

endmodule

>>> tb/sv/tb_base4096_encoder.sv
// Self-checking testbench for the base-4096 encoder with symbol scoreboard.

typedef struct packed {
    logic [15:0] symbol;
    logic        last;
} t_sym_item;

class symbol_scoreboard;
    logic [15:0]     limit;
    b4k_pkg::t_phase phase;
    logic [7:0]      held;
    logic [15:0]     sent;
    t_sym_item       expected_symbols[$];
    int              failures;

    function new();
        limit    = b4k_pkg::LIMIT_RESET;
        phase    = b4k_pkg::PH_0;
        held     = 8'h00;
        sent     = 16'h0000;
        failures = 0;
    endfunction

    function void set_limit(logic [15:0] value);
        limit = value;
    endfunction

    function int pending();
        return expected_symbols.size();
    endfunction

    // Drop the symbol once the message has reached its limit.
    function void keep_symbol(logic [15:0] sym, logic closes);
        t_sym_item item;
        if (sent >= limit)
            return;
        sent = sent + 16'd1;
        item.symbol = sym;
        item.last   = closes || (sent == limit);
        expected_symbols.push_back(item);
    endfunction

    function void take_byte(logic [7:0] data, logic eom);
        case (phase)
            b4k_pkg::PH_1: begin
                keep_symbol({4'h0, held, data[7:4]}, 1'b0);
                if (eom) begin
                    keep_symbol({4'h0, data[3:0], 8'h00}, 1'b0);
                    keep_symbol(b4k_pkg::PAD_SYMBOL, 1'b1);
                end else begin
                    held  = data;
                    phase = b4k_pkg::PH_2;
                end
            end
            b4k_pkg::PH_2: begin
                keep_symbol({4'h0, held[3:0], data}, eom);
                phase = b4k_pkg::PH_0;
                held  = 8'h00;
            end
            default: begin
                if (eom) begin
                    keep_symbol({4'h0, data, 4'h0}, 1'b1);
                end else begin
                    held  = data;
                    phase = b4k_pkg::PH_1;
                end
            end
        endcase
        if (eom) begin
            phase = b4k_pkg::PH_0;
            held  = 8'h00;
            sent  = 16'h0000;
        end
    endfunction

    function void report_error(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    function void check_symbol(logic [15:0] sym, logic last);
        t_sym_item exp_item;
        if (expected_symbols.size() == 0) begin
            report_error($sformatf("unexpected symbol %h last %b", sym, last));
            return;
        end
        exp_item = expected_symbols.pop_front();
        if (sym !== exp_item.symbol)
            report_error($sformatf("symbol mismatch: expected %h, got %h",
                                   exp_item.symbol, sym));
        if (last !== exp_item.last)
            report_error($sformatf("last flag mismatch on symbol %h: expected %b, got %b",
                                   exp_item.symbol, exp_item.last, last));
    endfunction
endclass

module tb_base4096_encoder;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BYTES    = 110;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] data_byte
    logic        i_s_tlast;   // end_of_message
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [15:0] symbol
    logic        o_m_tlast;   // last_symbol
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;  // [15:0] symbol_limit

    symbol_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;

    base4096_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.take_byte(i_s_tdata, i_s_tlast);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_limit(i_cfg_data);
            if (o_m_tvalid && i_m_tready)
                sb.check_symbol(o_m_tdata, o_m_tlast);
        end
    end

    // End the run if no transfer happens on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= eom;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Hold off until every expected symbol has left and the pipeline has settled.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int idle, input int stall, input logic [15:0] lim);
        int count;
        int len;
        int pick;
        logic [7:0] data;
        count = 0;
        write_limit(lim);
        send_idle_pct = idle;
        stall_pct     = stall;
        while (count < PHASE_BYTES) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 30);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 9);
                data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                send_byte(data, k == len - 1);
            end
            count += len;
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 8'h00;
        i_s_tlast     = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 16'h0000;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-byte tail, two-byte tail with pad, full groups.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);

        // A zero limit silences the whole message.
        write_limit(16'h0000);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);

        // A limit of one keeps the first symbol and flags it last.
        write_limit(16'h0001);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);

        // Lower the limit to the count reached in mid-message.
        write_limit(16'hFFFF);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        write_limit(16'h0002);
        send_byte(8'h55, 1'b1);

        run_random_phase(0, 0, 16'hFFFF);
        run_random_phase(84, 0, 16'($urandom_range(1, 5)));
        run_random_phase(0, 84, 16'($urandom_range(6, 40)));
        run_random_phase(35, 35, 16'h0003);

        wait_idle();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
